@@ hw/rtl/wprt_pkg.sv @@
// Shared types, widths and helpers for the weighted point rigid transform.
package wprt_pkg;

   localparam int VAL_W      = 32;
   localparam int COEF_W     = 16;
   localparam int ROW_W      = 3 * COEF_W;
   localparam int N_AXES     = 3;
   localparam int N_PAIRS    = 6;
   localparam int PPROD_W    = VAL_W + COEF_W;
   localparam int CPROD_W    = 2 * COEF_W;
   localparam int WPROD_W    = 64;
   localparam int DEN_W      = 2 * VAL_W;
   localparam int QUO_W      = VAL_W;
   localparam int REM_W      = DEN_W + QUO_W + 1;
   localparam int SUM_W      = WPROD_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ROW_W;

   // Pipeline depth of one lane: square, divider setup, one stage per
   // quotient bit, weight product.
   localparam int LANE_DEPTH = QUO_W + 3;

   localparam logic [CSR_IDX_W-1:0] REG_ROT_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

   // Row and column of each unique entry of the symmetric weight matrix.
   localparam int PAIR_I [N_PAIRS] = '{0, 0, 0, 1, 1, 2};
   localparam int PAIR_J [N_PAIRS] = '{0, 1, 2, 1, 2, 2};

   typedef logic [N_AXES-1:0][COEF_W-1:0]   coef_vec_type;
   typedef logic [N_AXES-1:0][PPROD_W-1:0]  pprod_vec_type;
   typedef logic [N_PAIRS-1:0][CPROD_W-1:0] cprod_vec_type;
   typedef logic [N_PAIRS-1:0][WPROD_W-1:0] wprod_vec_type;
   typedef logic [N_AXES-1:0][VAL_W-1:0]    pos_vec_type;
   typedef logic [N_PAIRS-1:0][VAL_W-1:0]   wmat_vec_type;

   function automatic logic [VAL_W-1:0] sat_word(input logic signed [SUM_W-1:0] x);
      logic [VAL_W-1:0] r;
      if (x > SUM_W'(64'sh7fffffff)) begin
         r = 32'h7fffffff;
      end else if (x < -SUM_W'(64'sh80000000)) begin
         r = 32'h80000000;
      end else begin
         r = x[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/wprt_if.sv @@
// Channel interfaces: point request, transformed result and register writes.
interface wprt_req_if;
   logic                      valid;
   logic                      ready;
   logic signed [31:0]        pos_x;
   logic signed [31:0]        pos_y;
   logic signed [31:0]        pos_z;
   logic [31:0]               spread_x;
   logic [31:0]               spread_y;
   logic [31:0]               spread_z;
   logic                      sigma_mode;
   modport source (output valid, pos_x, pos_y, pos_z, spread_x, spread_y, spread_z,
                   sigma_mode, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, spread_x, spread_y, spread_z,
                 sigma_mode, output ready);
endinterface

interface wprt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [31:0] w_xx;
   logic signed [31:0] w_xy;
   logic signed [31:0] w_xz;
   logic signed [31:0] w_yy;
   logic signed [31:0] w_yz;
   logic signed [31:0] w_zz;
   modport source (output valid, out_x, out_y, out_z, w_xx, w_xy, w_xz, w_yy, w_yz, w_zz,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, w_xx, w_xy, w_xz, w_yy, w_yz, w_zz,
                 output ready);
endinterface

interface wprt_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/weighted_point_rigid_transform_core.sv @@
// Top level of the weighted point rigid transform core.
//
// Usage:
//   req_chan carries one point per request: position, three spreads and a
//   mode bit (sigma_mode = 1: spreads are sigmas, weight 1/s^2, zero sigma
//   gives weight 0; sigma_mode = 0: spreads are the weights).
//   rsp_chan returns r' = R r + T and the six unique entries of R W R^T,
//   all Q16.16 and saturated to the signed 32-bit range.
//   csr_chan writes the rotation rows and translation (index = register
//   number); it is always ready. Write it only while no request is in flight.
// Timing:
//   Three axis lanes run side by side; each turns its spread into a weight
//   with a 32-stage restoring divider (one quotient bit per stage). One
//   request is taken every cycle while the response side keeps up.
// Reset clears all in-flight requests and loads the identity rotation and
// zero translation. When the receiver stalls, the whole pipeline holds and
// req_chan.ready drops until the held response is taken.
module weighted_point_rigid_transform_core #(
   parameter int VALUE_FRAC_BITS = 16,
   parameter int COEF_FRAC_BITS  = 14
) (
   input  logic        clock,
   input  logic        reset,
   wprt_req_if.sink    req_chan,
   wprt_rsp_if.source  rsp_chan,
   wprt_csr_if.sink    csr_chan
);
   import wprt_pkg::*;

   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

   logic [N_AXES-1:0][ROW_W-1:0] rot_ff;
   logic [N_AXES-1:0][ROW_W-1:0] rot_in;
   pos_vec_type                  shift_ff;
   pos_vec_type                  shift_in;

   logic [LANE_DEPTH-1:0] vld_ff;
   logic [LANE_DEPTH-1:0] vld_in;
   logic                  out_vld_ff;
   logic                  out_vld_in;
   logic                  pipe_en;

   logic signed [VAL_W-1:0] pos_a    [N_AXES];
   logic [VAL_W-1:0]        spread_a [N_AXES];
   coef_vec_type            col_a    [N_AXES];
   pprod_vec_type           pp_a     [N_AXES];
   wprod_vec_type           wp_a     [N_AXES];
   pos_vec_type             pos_res;
   wmat_vec_type            w_res;

   // Advance everything unless a finished response sits unread.
   assign pipe_en        = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = pipe_en;
   assign csr_chan.ready = 1'b1;

   // Register writes; unknown indexes are dropped.
   always_comb begin
      rot_in   = rot_ff;
      shift_in = shift_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_ROT_X:   rot_in[0]   = csr_chan.data;
            REG_ROT_Y:   rot_in[1]   = csr_chan.data;
            REG_ROT_Z:   rot_in[2]   = csr_chan.data;
            REG_SHIFT_X: shift_in[0] = csr_chan.data[VAL_W-1:0];
            REG_SHIFT_Y: shift_in[1] = csr_chan.data[VAL_W-1:0];
            REG_SHIFT_Z: shift_in[2] = csr_chan.data[VAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= {COEF_ONE, {(2*COEF_W){1'b0}}};
         rot_ff[1] <= {{COEF_W{1'b0}}, COEF_ONE, {COEF_W{1'b0}}};
         rot_ff[2] <= {{(2*COEF_W){1'b0}}, COEF_ONE};
         shift_ff  <= '0;
      end else begin
         rot_ff   <= rot_in;
         shift_ff <= shift_in;
      end
   end

   // Valid tracking follows the lane pipeline; the merge register is the
   // output register.
   assign vld_in     = pipe_en ? {vld_ff[LANE_DEPTH-2:0], req_chan.valid} : vld_ff;
   assign out_vld_in = pipe_en ? vld_ff[LANE_DEPTH-1] : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign pos_a[0]    = req_chan.pos_x;
   assign pos_a[1]    = req_chan.pos_y;
   assign pos_a[2]    = req_chan.pos_z;
   assign spread_a[0] = req_chan.spread_x;
   assign spread_a[1] = req_chan.spread_y;
   assign spread_a[2] = req_chan.spread_z;

   // Lane k sees column k of R: coefficient R[i][k] from row i.
   for (genvar k = 0; k < N_AXES; k++) begin : g_lane
      for (genvar i = 0; i < N_AXES; i++) begin : g_col
         assign col_a[k][i] = rot_ff[i][COEF_W*(N_AXES-1-k) +: COEF_W];
      end

      wprt_lane #(
         .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
      ) u_lane (
         .clock      (clock),
         .en         (pipe_en),
         .pos        (pos_a[k]),
         .spread     (spread_a[k]),
         .sigma_mode (req_chan.sigma_mode),
         .col        (col_a[k]),
         .pp_out     (pp_a[k]),
         .wp_out     (wp_a[k])
      );
   end

   wprt_merge #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_merge (
      .clock   (clock),
      .en      (pipe_en),
      .pp      (pp_a),
      .wp      (wp_a),
      .shift   (shift_ff),
      .pos_out (pos_res),
      .w_out   (w_res)
   );

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.out_x = pos_res[0];
   assign rsp_chan.out_y = pos_res[1];
   assign rsp_chan.out_z = pos_res[2];
   assign rsp_chan.w_xx  = w_res[0];
   assign rsp_chan.w_xy  = w_res[1];
   assign rsp_chan.w_xz  = w_res[2];
   assign rsp_chan.w_yy  = w_res[3];
   assign rsp_chan.w_yz  = w_res[4];
   assign rsp_chan.w_zz  = w_res[5];

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (vld_ff == '0) && !out_vld_ff)
      else $error("pipeline not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff) && out_vld_ff)
      else $error("pipeline moved while output stalled");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(vld_ff[LANE_DEPTH-1]))
      else $error("response without a request at the lane output");
`endif

endmodule

@@ hw/rtl/wprt_lane.sv @@
// One axis lane: weight from spread, pipelined divider, per-axis products.
module wprt_lane #(
   parameter int VALUE_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [31:0]    pos,
   input  logic [31:0]           spread,
   input  logic                  sigma_mode,
   input  wprt_pkg::coef_vec_type  col,
   output wprt_pkg::pprod_vec_type pp_out,
   output wprt_pkg::wprod_vec_type wp_out
);
   import wprt_pkg::*;

   localparam logic [REM_W-1:0] NUMER = REM_W'(1) << (3 * VALUE_FRAC_BITS);

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             sat;
      logic             zero;
      logic             mode;
      logic [VAL_W-1:0] spread;
      pprod_vec_type    pp;
      cprod_vec_type    cc;
   } dstg_type;

   logic [DEN_W-1:0] den1_ff;
   logic [VAL_W-1:0] spread1_ff;
   logic             mode1_ff;
   pprod_vec_type    pp1_ff;
   cprod_vec_type    cc1_ff;
   pprod_vec_type    pp_c;
   cprod_vec_type    cc_c;
   logic [DEN_W-1:0] sq_c;

   dstg_type         dv_ff [QUO_W+1];
   dstg_type         dv_in [QUO_W+1];
   logic [REM_W-1:0] sub_c [QUO_W];

   logic [VAL_W-1:0] wgt_c;
   wprod_vec_type    wp_c;
   wprod_vec_type    wp_ff;
   pprod_vec_type    pp_ff;

   assign sq_c = DEN_W'(spread) * DEN_W'(spread);

   always_comb begin
      for (int i = 0; i < N_AXES; i++) begin
         pp_c[i] = PPROD_W'($signed(col[i])) * PPROD_W'(pos);
      end
      for (int n = 0; n < N_PAIRS; n++) begin
         cc_c[n] = CPROD_W'($signed(col[PAIR_I[n]])) * CPROD_W'($signed(col[PAIR_J[n]]));
      end
   end

   // Divider setup flags quotients that overflow 32 bits up front; then
   // restoring division, one quotient bit per stage, MSB first.
   always_comb begin
      dv_in[0].rem    = NUMER;
      dv_in[0].den    = den1_ff;
      dv_in[0].quo    = '0;
      dv_in[0].sat    = (REM_W'({den1_ff, {QUO_W{1'b0}}}) <= NUMER);
      dv_in[0].zero   = (spread1_ff == '0);
      dv_in[0].mode   = mode1_ff;
      dv_in[0].spread = spread1_ff;
      dv_in[0].pp     = pp1_ff;
      dv_in[0].cc     = cc1_ff;
      for (int s = 0; s < QUO_W; s++) begin
         sub_c[s]   = REM_W'(dv_ff[s].den) << (QUO_W - 1 - s);
         dv_in[s+1] = dv_ff[s];
         if (!dv_ff[s].sat && (dv_ff[s].rem >= sub_c[s])) begin
            dv_in[s+1].rem                = dv_ff[s].rem - sub_c[s];
            dv_in[s+1].quo[QUO_W - 1 - s] = 1'b1;
         end
      end
   end

   always_comb begin
      if (!dv_ff[QUO_W].mode) begin
         wgt_c = dv_ff[QUO_W].spread;
      end else if (dv_ff[QUO_W].zero) begin
         wgt_c = '0;
      end else if (dv_ff[QUO_W].sat) begin
         wgt_c = '1;
      end else begin
         wgt_c = dv_ff[QUO_W].quo;
      end
      for (int n = 0; n < N_PAIRS; n++) begin
         wp_c[n] = WPROD_W'($signed(dv_ff[QUO_W].cc[n])) * $signed({32'b0, wgt_c});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den1_ff    <= sq_c;
         spread1_ff <= spread;
         mode1_ff   <= sigma_mode;
         pp1_ff     <= pp_c;
         cc1_ff     <= cc_c;
         for (int s = 0; s <= QUO_W; s++) begin
            dv_ff[s] <= dv_in[s];
         end
         wp_ff <= wp_c;
         pp_ff <= dv_ff[QUO_W].pp;
      end
   end

   assign pp_out = pp_ff;
   assign wp_out = wp_ff;

endmodule

@@ hw/rtl/wprt_merge.sv @@
// Merge stage: sum lane products, scale, translate and saturate.
module wprt_merge #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    en,
   input  wprt_pkg::pprod_vec_type pp [3],
   input  wprt_pkg::wprod_vec_type wp [3],
   input  wprt_pkg::pos_vec_type   shift,
   output wprt_pkg::pos_vec_type   pos_out,
   output wprt_pkg::wmat_vec_type  w_out
);
   import wprt_pkg::*;

   logic signed [PPROD_W+1:0] acc_c [N_AXES];
   logic signed [SUM_W-1:0]   tot_c [N_AXES];
   logic signed [SUM_W-1:0]   ws_c  [N_PAIRS];
   pos_vec_type               pos_c;
   wmat_vec_type              w_c;
   pos_vec_type               pos_ff;
   wmat_vec_type              w_ff;

   always_comb begin
      for (int i = 0; i < N_AXES; i++) begin
         acc_c[i] = (PPROD_W+2)'($signed(pp[0][i])) + (PPROD_W+2)'($signed(pp[1][i]))
                  + (PPROD_W+2)'($signed(pp[2][i]));
         tot_c[i] = SUM_W'(acc_c[i] >>> COEF_FRAC_BITS) + SUM_W'($signed(shift[i]));
         pos_c[i] = sat_word(tot_c[i]);
      end
      for (int n = 0; n < N_PAIRS; n++) begin
         ws_c[n] = SUM_W'($signed(wp[0][n])) + SUM_W'($signed(wp[1][n]))
                 + SUM_W'($signed(wp[2][n]));
         w_c[n]  = sat_word(ws_c[n] >>> (2 * COEF_FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= pos_c;
         w_ff   <= w_c;
      end
   end

   assign pos_out = pos_ff;
   assign w_out   = w_ff;

endmodule
